/* hdl/etc_pkg.sv */
`timescale 1ns / 1ps

package etc_pkg;

   // tick counter width (counts accepted ticks while capturing), timestamps keep the low TsWidth bits
   localparam int StampWidth = 32;
   localparam int TsWidth    = 32;
   localparam int QuietWidth = 32;
   localparam int CountWidth = 10;

   localparam logic [QuietWidth-1:0] QuietTicksReset = QuietWidth'(200 * 1000 * 10);
   localparam logic [CountWidth:0]   BytesPerRecord  = (CountWidth + 1)'(4);
   localparam logic [CountWidth:0]   CountMax        = (CountWidth + 1)'(1023);

   // queue between front and back
   localparam int QueueDepth      = 4;
   localparam int QueueAddrWidth  = $clog2(QueueDepth);
   localparam int QueueCountWidth = $clog2(QueueDepth + 1);

   // request operations
   localparam logic OpStart = 1'b0;
   localparam logic OpTick  = 1'b1;

   // result codes
   localparam logic KindEdge = 1'b0;
   localparam logic KindEnd  = 1'b1;
   localparam logic ChanClk  = 1'b0;
   localparam logic ChanData = 1'b1;

   // record slots of one bundle, emitted lowest first
   localparam int RecClk   = 0;
   localparam int RecData  = 1;
   localparam int RecEnd   = 2;
   localparam int RecCount = 3;

   typedef struct packed {
      logic [RecCount-1:0]   mask;
      logic                  clk_rise;
      logic                  data_rise;
      logic [TsWidth-1:0]    timestamp;
      logic [CountWidth-1:0] clk_bytes;
      logic [CountWidth-1:0] data_bytes;
   } etc_bundle_type;

   typedef struct packed {
      logic full;
      logic empty;
   } etc_fifo_status_type;

endpackage

/* hdl/etc_front.sv */
`timescale 1ns / 1ps

module etc_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   input  logic                                req_operation,
   input  logic [etc_pkg::CountWidth-1:0]      req_byte_limit,
   input  logic                                req_clk_level,
   input  logic                                req_data_level,
   input  logic                                csr_wr_en,
   input  logic [etc_pkg::QuietWidth-1:0]      csr_wr_data,
   input  etc_pkg::etc_fifo_status_type        fifo_status,
   output logic                                bundle_push,
   output etc_pkg::etc_bundle_type             bundle
);

   typedef enum logic [2:0] {
      PhIdle    = 3'b001,
      PhQuiet   = 3'b010,
      PhCapture = 3'b100
   } phase_type;

   phase_type                         phase_ff, phase_in;
   logic [etc_pkg::QuietWidth-1:0]    quiet_ticks_ff, quiet_ticks_in;
   logic [etc_pkg::QuietWidth-1:0]    quiet_cnt_ff, quiet_cnt_in;
   logic [etc_pkg::StampWidth-1:0]    tick_ff, tick_in;
   logic                              clk_prev_ff, clk_prev_in;
   logic                              data_prev_ff, data_prev_in;
   logic [etc_pkg::CountWidth-1:0]    clk_bytes_ff, clk_bytes_in;
   logic [etc_pkg::CountWidth-1:0]    data_bytes_ff, data_bytes_in;
   logic [etc_pkg::CountWidth-1:0]    limit_ff, limit_in;

   logic                              accept;
   logic                              clk_edge, data_edge, done;
   logic [etc_pkg::CountWidth:0]      clk_sum, data_sum;
   logic [etc_pkg::CountWidth-1:0]    clk_bytes_next, data_bytes_next;

   assign accept    = req_push && !fifo_status.full;
   assign clk_edge  = req_clk_level != clk_prev_ff;
   assign data_edge = req_data_level != data_prev_ff;

   // saturating byte counts
   assign clk_sum  = {1'b0, clk_bytes_ff} + etc_pkg::BytesPerRecord;
   assign data_sum = {1'b0, data_bytes_ff} + etc_pkg::BytesPerRecord;

   always_comb begin
      clk_bytes_next  = clk_bytes_ff;
      data_bytes_next = data_bytes_ff;
      if (clk_edge) begin
         clk_bytes_next = (clk_sum > etc_pkg::CountMax) ?
                          etc_pkg::CountMax[etc_pkg::CountWidth-1:0] :
                          clk_sum[etc_pkg::CountWidth-1:0];
      end
      if (data_edge) begin
         data_bytes_next = (data_sum > etc_pkg::CountMax) ?
                           etc_pkg::CountMax[etc_pkg::CountWidth-1:0] :
                           data_sum[etc_pkg::CountWidth-1:0];
      end
   end

   assign done = (clk_bytes_next >= limit_ff) || (data_bytes_next >= limit_ff);

   always_comb begin
      phase_in       = phase_ff;
      quiet_ticks_in = csr_wr_en ? csr_wr_data : quiet_ticks_ff;
      quiet_cnt_in   = quiet_cnt_ff;
      tick_in        = tick_ff;
      clk_prev_in    = clk_prev_ff;
      data_prev_in   = data_prev_ff;
      clk_bytes_in   = clk_bytes_ff;
      data_bytes_in  = data_bytes_ff;
      limit_in       = limit_ff;
      bundle_push    = 1'b0;

      bundle.mask              = '0;
      bundle.mask[etc_pkg::RecClk]  = clk_edge;
      bundle.mask[etc_pkg::RecData] = data_edge;
      bundle.mask[etc_pkg::RecEnd]  = done;
      bundle.clk_rise   = req_clk_level;
      bundle.data_rise  = req_data_level;
      bundle.timestamp  = etc_pkg::TsWidth'(tick_ff);
      bundle.clk_bytes  = clk_bytes_next;
      bundle.data_bytes = data_bytes_next;

      if (accept) begin
         if (req_operation == etc_pkg::OpStart) begin
            phase_in      = PhQuiet;
            limit_in      = req_byte_limit;
            quiet_cnt_in  = '0;
            tick_in       = '0;
            clk_prev_in   = 1'b0;
            data_prev_in  = 1'b0;
            clk_bytes_in  = '0;
            data_bytes_in = '0;
         end else begin
            case (phase_ff)
               PhQuiet: begin
                  if (req_clk_level) begin
                     quiet_cnt_in = '0;
                  end else if (quiet_cnt_ff >= quiet_ticks_ff) begin
                     phase_in     = PhCapture;
                     tick_in      = '0;
                     clk_prev_in  = 1'b0;
                     data_prev_in = 1'b0;
                  end else begin
                     quiet_cnt_in = quiet_cnt_ff + 1'b1;
                  end
               end
               PhCapture: begin
                  clk_prev_in   = req_clk_level;
                  data_prev_in  = req_data_level;
                  clk_bytes_in  = clk_bytes_next;
                  data_bytes_in = data_bytes_next;
                  tick_in       = tick_ff + 1'b1;
                  bundle_push   = clk_edge || data_edge || done;
                  if (done) begin
                     phase_in = PhIdle;
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PhIdle;
         quiet_ticks_ff <= etc_pkg::QuietTicksReset;
         quiet_cnt_ff   <= '0;
         tick_ff        <= '0;
         clk_prev_ff    <= 1'b0;
         data_prev_ff   <= 1'b0;
         clk_bytes_ff   <= '0;
         data_bytes_ff  <= '0;
         limit_ff       <= '0;
      end else begin
         phase_ff       <= phase_in;
         quiet_ticks_ff <= quiet_ticks_in;
         quiet_cnt_ff   <= quiet_cnt_in;
         tick_ff        <= tick_in;
         clk_prev_ff    <= clk_prev_in;
         data_prev_ff   <= data_prev_in;
         clk_bytes_ff   <= clk_bytes_in;
         data_bytes_ff  <= data_bytes_in;
         limit_ff       <= limit_in;
      end
   end

   // a bundle closing the capture always drops back to idle
   a_end_goes_idle: assert property (@(posedge clock) disable iff (reset)
      bundle_push && bundle.mask[etc_pkg::RecEnd] |=> phase_ff == PhIdle)
      else $error("capture did not end after end record");

endmodule

/* hdl/etc_fifo.sv */
`timescale 1ns / 1ps

module etc_fifo (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  etc_pkg::etc_bundle_type       push_data,
   input  logic                          pop,
   output etc_pkg::etc_bundle_type       head,
   output etc_pkg::etc_fifo_status_type  status
);

   etc_pkg::etc_bundle_type                entries_ff [etc_pkg::QueueDepth];
   logic [etc_pkg::QueueAddrWidth-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [etc_pkg::QueueAddrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [etc_pkg::QueueCountWidth-1:0]    count_ff, count_in;
   logic                                   do_push, do_pop;

   assign status.full  = count_ff == etc_pkg::QueueCountWidth'(etc_pkg::QueueDepth);
   assign status.empty = count_ff == '0;
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= etc_pkg::QueueCountWidth'(etc_pkg::QueueDepth))
      else $error("queue count beyond depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && status.full))
      else $error("bundle pushed into a full queue");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) || (count_ff == etc_pkg::QueueCountWidth'(etc_pkg::QueueDepth))
      || (wr_ptr_ff != rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule

/* hdl/etc_back.sv */
`timescale 1ns / 1ps

module etc_back (
   input  logic                                clock,
   input  logic                                reset,
   input  etc_pkg::etc_bundle_type             head,
   input  etc_pkg::etc_fifo_status_type        fifo_status,
   output logic                                fifo_pop,
   input  logic                                rsp_pop,
   output logic                                rsp_empty,
   output logic                                rsp_kind,
   output logic                                rsp_channel,
   output logic                                rsp_rising,
   output logic [etc_pkg::TsWidth-1:0]         rsp_timestamp,
   output logic [etc_pkg::CountWidth-1:0]      rsp_clk_byte_count,
   output logic [etc_pkg::CountWidth-1:0]      rsp_data_byte_count,
   output logic                                rsp_last
);

   etc_pkg::etc_bundle_type              cur_ff;
   logic [etc_pkg::RecCount-1:0]         mask_ff, mask_in;
   logic [etc_pkg::RecCount-1:0]         mask_left;
   logic                                 taken;

   assign rsp_empty = mask_ff == '0;
   assign taken     = rsp_pop && !rsp_empty;
   // drop the lowest pending record once it is taken
   assign mask_left = taken ? (mask_ff & (mask_ff - 1'b1)) : mask_ff;
   assign fifo_pop  = !fifo_status.empty && (mask_left == '0);
   assign mask_in   = fifo_pop ? head.mask : mask_left;

   always_comb begin
      rsp_kind            = etc_pkg::KindEdge;
      rsp_channel         = etc_pkg::ChanClk;
      rsp_rising          = 1'b0;
      rsp_clk_byte_count  = '0;
      rsp_data_byte_count = '0;
      rsp_last            = 1'b0;
      rsp_timestamp       = cur_ff.timestamp;
      if (mask_ff[etc_pkg::RecClk]) begin
         rsp_rising = cur_ff.clk_rise;
      end else if (mask_ff[etc_pkg::RecData]) begin
         rsp_channel = etc_pkg::ChanData;
         rsp_rising  = cur_ff.data_rise;
      end else begin
         rsp_kind            = etc_pkg::KindEnd;
         rsp_clk_byte_count  = cur_ff.clk_bytes;
         rsp_data_byte_count = cur_ff.data_bytes;
         rsp_last            = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (fifo_pop) begin
         cur_ff <= head;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> $stable(mask_ff) && $stable(cur_ff))
      else $error("pending records changed while stalled");

endmodule

/* hdl/edge_timestamp_capture.sv */
`timescale 1ns / 1ps

// path: with queue and output stage empty, a tick request's first record is held in the bundle
//   queue, then in the output stage, before it is on the rsp ports; its other records follow as popped
// throughput: one request per cycle while the bundle queue has room; the rsp side
//   drains one record per cycle while rsp_pop is held; the next bundle loads as the last record is taken
// reset: synchronous, active high; clears phase, counters, queue and output stage,
//   quiet_ticks returns to 2000000; no clearing pass

module edge_timestamp_capture (
   input  logic                                clock,
   input  logic                                reset,
   // request side
   input  logic                                req_push,
   output logic                                req_full,
   input  logic                                req_operation,
   input  logic [etc_pkg::CountWidth-1:0]      req_byte_limit,
   input  logic                                req_clk_level,
   input  logic                                req_data_level,
   // result side
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic                                rsp_kind,
   output logic                                rsp_channel,
   output logic                                rsp_rising,
   output logic [etc_pkg::TsWidth-1:0]         rsp_timestamp,
   output logic [etc_pkg::CountWidth-1:0]      rsp_clk_byte_count,
   output logic [etc_pkg::CountWidth-1:0]      rsp_data_byte_count,
   output logic                                rsp_last,
   // quiet_ticks register
   input  logic                                csr_wr_en,
   input  logic [etc_pkg::QuietWidth-1:0]      csr_wr_data
);

   etc_pkg::etc_fifo_status_type  fifo_status;
   etc_pkg::etc_bundle_type       push_bundle;
   etc_pkg::etc_bundle_type       head_bundle;
   logic                          bundle_push;
   logic                          fifo_pop;

   // the front only stalls on a full queue, never on the rsp side directly
   assign req_full = fifo_status.full;

   // front: start/quiet/capture sequencing, edge detect and byte counting,
   // one bundle of up to three records per tick
   etc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_operation  (req_operation),
      .req_byte_limit (req_byte_limit),
      .req_clk_level  (req_clk_level),
      .req_data_level (req_data_level),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .fifo_status    (fifo_status),
      .bundle_push    (bundle_push),
      .bundle         (push_bundle)
   );

   // short queue decoupling front from back
   etc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (bundle_push),
      .push_data (push_bundle),
      .pop       (fifo_pop),
      .head      (head_bundle),
      .status    (fifo_status)
   );

   // back: unpacks a bundle into records in clock, data, end order
   etc_back u_back (
      .clock               (clock),
      .reset               (reset),
      .head                (head_bundle),
      .fifo_status         (fifo_status),
      .fifo_pop            (fifo_pop),
      .rsp_pop             (rsp_pop),
      .rsp_empty           (rsp_empty),
      .rsp_kind            (rsp_kind),
      .rsp_channel         (rsp_channel),
      .rsp_rising          (rsp_rising),
      .rsp_timestamp       (rsp_timestamp),
      .rsp_clk_byte_count  (rsp_clk_byte_count),
      .rsp_data_byte_count (rsp_data_byte_count),
      .rsp_last            (rsp_last)
   );

endmodule
